FILE: rtl/core/accel_calibrated_tilt_defines.svh
`ifndef ACCEL_CALIBRATED_TILT_DEFINES_SVH
`define ACCEL_CALIBRATED_TILT_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset.
`define ACT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define ACT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/act_pkg.sv
package act_pkg;

    localparam int SAMPLE_BITS      = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int SQRT_STEPS       = 16;
    localparam int OFF_W            = 24;
    localparam int GAIN_W           = 16;
    localparam int CFG_IDX_W        = 3;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [OFF_W-1:0]  OFF_X_RST  = 24'd12859;
    localparam logic [OFF_W-1:0]  OFF_Y_RST  = 24'd4920;
    localparam logic [OFF_W-1:0]  OFF_Z_RST  = 24'd14134;
    localparam logic [GAIN_W-1:0] GAIN_X_RST = 16'd17069;
    localparam logic [GAIN_W-1:0] GAIN_Y_RST = 16'd16423;
    localparam logic [GAIN_W-1:0] GAIN_Z_RST = 16'd16135;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X = 3'd0,
        CFG_OFFSET_Y = 3'd1,
        CFG_OFFSET_Z = 3'd2,
        CFG_GAIN_X   = 3'd3,
        CFG_GAIN_Y   = 3'd4,
        CFG_GAIN_Z   = 3'd5
    } cfg_idx_t;

    typedef logic [2:0][OFF_W-1:0]  off_vec_t;
    typedef logic [2:0][GAIN_W-1:0] gain_vec_t;

    typedef struct packed {
        off_vec_t  off;
        gain_vec_t gain;
    } cal_cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x;
        logic signed [SAMPLE_BITS-1:0] y;
        logic signed [SAMPLE_BITS-1:0] z;
    } axes_t;

    // atan(2^-i) in units of 2^-16 degree
    function automatic logic [22:0] atan_val(input int i);
        logic [22:0] v;
        begin
            case (i)
                0:  v = 23'd2949120;
                1:  v = 23'd1740967;
                2:  v = 23'd919879;
                3:  v = 23'd466945;
                4:  v = 23'd234379;
                5:  v = 23'd117304;
                6:  v = 23'd58666;
                7:  v = 23'd29335;
                8:  v = 23'd14668;
                9:  v = 23'd7334;
                10: v = 23'd3667;
                11: v = 23'd1833;
                12: v = 23'd917;
                13: v = 23'd458;
                14: v = 23'd229;
                15: v = 23'd115;
                16: v = 23'd57;
                17: v = 23'd29;
                18: v = 23'd14;
                19: v = 23'd7;
                20: v = 23'd4;
                21: v = 23'd2;
                22: v = 23'd1;
                default: v = 23'd0;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: rtl/core/accel_calibrated_tilt.sv
// Calibrated accelerometer axes with pitch and roll.
// Input channel: in_valid / in_stall with accel_x, accel_y, accel_z in mg;
// an item is taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with calib_x/y/z in mg and
// pitch_angle, roll_angle in hundredths of a degree; one result per item.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index
// 0..2 are the axis offsets (1/256 mg), 3..5 the Q2.14 gains. cfg_ready is
// always high; write only while no item is in flight.
// Stages: two calibration stages, the queue, squares, sixteen square
// root stages, a CORDIC load stage, one CORDIC stage per iteration and
// the angle scaling stage. One item per cycle enters and leaves while
// nothing stalls; the CORDIC and root pipelines set the depth. When
// out_stall is high and a result waits, the back pipeline holds, the
// four-entry queue fills and then in_stall rises. Reset empties the
// pipeline and queue and loads the default offsets and gains.
module accel_calibrated_tilt
#(
    parameter int CORDIC_STEPS = act_pkg::CORDIC_STEPS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [15:0]                 accel_x,
    input  logic signed [15:0]                 accel_y,
    input  logic signed [15:0]                 accel_z,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [15:0]                 calib_x,
    output logic signed [15:0]                 calib_y,
    output logic signed [15:0]                 calib_z,
    output logic signed [14:0]                 pitch_angle,
    output logic signed [14:0]                 roll_angle,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [act_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [act_pkg::OFF_W-1:0]          cfg_data
);

    act_pkg::cal_cfg_t cfg_reg;
    act_pkg::axes_t    push_data;
    act_pkg::axes_t    pop_data;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.off[0]  <= act_pkg::OFF_X_RST;
            cfg_reg.off[1]  <= act_pkg::OFF_Y_RST;
            cfg_reg.off[2]  <= act_pkg::OFF_Z_RST;
            cfg_reg.gain[0] <= act_pkg::GAIN_X_RST;
            cfg_reg.gain[1] <= act_pkg::GAIN_Y_RST;
            cfg_reg.gain[2] <= act_pkg::GAIN_Z_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                act_pkg::CFG_OFFSET_X: cfg_reg.off[0]  <= cfg_data;
                act_pkg::CFG_OFFSET_Y: cfg_reg.off[1]  <= cfg_data;
                act_pkg::CFG_OFFSET_Z: cfg_reg.off[2]  <= cfg_data;
                act_pkg::CFG_GAIN_X:   cfg_reg.gain[0] <= cfg_data[act_pkg::GAIN_W-1:0];
                act_pkg::CFG_GAIN_Y:   cfg_reg.gain[1] <= cfg_data[act_pkg::GAIN_W-1:0];
                act_pkg::CFG_GAIN_Z:   cfg_reg.gain[2] <= cfg_data[act_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    act_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .accel_x  (accel_x),
        .accel_y  (accel_y),
        .accel_z  (accel_z),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    act_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    act_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (pop_data),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .calib_x     (calib_x),
        .calib_y     (calib_y),
        .calib_z     (calib_z),
        .pitch_angle (pitch_angle),
        .roll_angle  (roll_angle)
    );

endmodule

FILE: rtl/core/act_front.sv
module act_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [act_pkg::SAMPLE_BITS-1:0] accel_x,
    input  logic signed [act_pkg::SAMPLE_BITS-1:0] accel_y,
    input  logic signed [act_pkg::SAMPLE_BITS-1:0] accel_z,
    input  act_pkg::cal_cfg_t                   cfg,
    input  logic                                q_full,
    output logic                                q_push,
    output act_pkg::axes_t                      q_data
);

    localparam int DW = act_pkg::OFF_W + 1;
    localparam int PW = DW + act_pkg::GAIN_W + 1;

    logic signed [act_pkg::SAMPLE_BITS-1:0] raw [3];
    logic signed [DW-1:0] diff_reg [3];
    logic signed [PW-1:0] prod_reg [3];
    logic signed [act_pkg::SAMPLE_BITS-1:0] calib [3];
    logic va_reg;
    logic vb_reg;
    logic fen;

    assign raw[0] = accel_x;
    assign raw[1] = accel_y;
    assign raw[2] = accel_z;

    assign fen      = !vb_reg || !q_full;
    assign in_stall = !fen;
    assign q_push   = vb_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (fen)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_axis
        logic signed [DW-1:0] diff_next;
        logic signed [PW-1:0] rnd;
        logic signed [PW-23:0] q;

        assign diff_next = (DW'(raw[k]) <<< 8)
                         - DW'($signed(cfg.off[k]));
        // round half up, then drop the 22 fraction bits
        assign rnd = prod_reg[k] + PW'(64'sd2097152);
        assign q   = rnd[PW-1:22];

        always_comb
        begin
            if (q > (PW-22)'(32767))
                calib[k] = 16'sh7FFF;
            else if (q < -(PW-22)'(32768))
                calib[k] = -16'sh8000;
            else
                calib[k] = q[15:0];
        end

        always_ff @(posedge clk)
        begin
            if (fen)
            begin
                diff_reg[k] <= diff_next;
                prod_reg[k] <= diff_reg[k] * $signed({1'b0, cfg.gain[k]});
            end
        end
    end

    assign q_data.x = calib[0];
    assign q_data.y = calib[1];
    assign q_data.z = calib[2];

endmodule

FILE: rtl/core/act_queue.sv
`include "accel_calibrated_tilt_defines.svh"

module act_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  act_pkg::axes_t push_data,
    output logic           full,
    input  logic           pop,
    output act_pkg::axes_t pop_data,
    output logic           empty
);

    localparam int AW = $clog2(act_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(act_pkg::QUEUE_DEPTH + 1);

    act_pkg::axes_t mem [act_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full     = (count_reg == CW'(act_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    `ACT_ASSERT_NOW(a_no_overflow, push, !full || pop, "item pushed into full queue")
    `ACT_ASSERT_NOW(a_no_underflow, pop, !empty, "item popped from empty queue")
    `ACT_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "count lost")

endmodule

FILE: rtl/core/act_back.sv
module act_back
#(
    parameter int CORDIC_STEPS = act_pkg::CORDIC_STEPS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  act_pkg::axes_t                      q_data,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [15:0]                  calib_x,
    output logic signed [15:0]                  calib_y,
    output logic signed [15:0]                  calib_z,
    output logic signed [14:0]                  pitch_angle,
    output logic signed [14:0]                  roll_angle
);

    localparam int CS    = (CORDIC_STEPS > act_pkg::ATAN_ENTRIES) ?
                           act_pkg::ATAN_ENTRIES : CORDIC_STEPS;
    localparam int SQS   = act_pkg::SQRT_STEPS;
    localparam int P_CI  = SQS + 1;
    localparam int P_OUT = P_CI + CS + 1;
    localparam int XW    = 28;
    localparam int ZW    = 25;

    logic                 v_reg    [0:P_OUT];
    act_pkg::axes_t       axes_reg [0:P_OUT];
    logic [32:0]          rem_reg  [0:SQS][0:1];
    logic [15:0]          root_reg [0:SQS][0:1];
    logic signed [XW-1:0] cx_reg   [0:CS][0:1];
    logic signed [XW-1:0] cy_reg   [0:CS][0:1];
    logic signed [ZW-1:0] cz_reg   [0:CS][0:1];
    logic signed [14:0]   ang_reg  [0:1];
    logic signed [31:0]   sq_x;
    logic signed [31:0]   sq_y;
    logic signed [31:0]   sq_z;
    logic en;

    // one enable for the whole pipe: hold everything while the result waits
    assign en    = !(v_reg[P_OUT] && out_stall);
    assign q_pop = en && !q_empty;

    assign sq_x = 32'(q_data.x) * 32'(q_data.x);
    assign sq_y = 32'(q_data.y) * 32'(q_data.y);
    assign sq_z = 32'(q_data.z) * 32'(q_data.z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p <= P_OUT; p++)
                v_reg[p] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= q_pop;
            for (int p = 1; p <= P_OUT; p++)
                v_reg[p] <= v_reg[p-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            axes_reg[0]    <= q_data;
            rem_reg[0][0]  <= {1'b0, sq_x} + {1'b0, sq_z};
            rem_reg[0][1]  <= {1'b0, sq_y} + {1'b0, sq_z};
            root_reg[0][0] <= '0;
            root_reg[0][1] <= '0;
            for (int p = 1; p <= P_OUT; p++)
                axes_reg[p] <= axes_reg[p-1];
        end
    end

    // lane 0 is pitch, lane 1 is roll
    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic signed [15:0] num_ci;
        logic signed [15:0] num_out;
        logic               root_zero;
        logic signed [32:0] zp;
        logic signed [32:0] hs;
        logic signed [16:0] h;
        logic signed [14:0] ang_next;

        assign num_ci  = (l == 0) ? axes_reg[SQS].y : axes_reg[SQS].x;
        assign num_out = (l == 0) ? axes_reg[P_CI+CS].y : axes_reg[P_CI+CS].x;
        assign root_zero = ((l == 0) ? (axes_reg[P_CI+CS].x == '0)
                                     : (axes_reg[P_CI+CS].y == '0))
                           && (axes_reg[P_CI+CS].z == '0);

        // floor square root, one result bit a stage
        for (genvar k = 0; k < SQS; k++)
        begin : g_sqrt
            localparam int B = SQS - 1 - k;
            logic [32:0] trial;

            assign trial = ({17'd0, root_reg[k][l]} << (B + 1)) + (33'd1 << (2 * B));

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (rem_reg[k][l] >= trial)
                    begin
                        rem_reg[k+1][l]  <= rem_reg[k][l] - trial;
                        root_reg[k+1][l] <= root_reg[k][l] | (16'd1 << B);
                    end
                    else
                    begin
                        rem_reg[k+1][l]  <= rem_reg[k][l];
                        root_reg[k+1][l] <= root_reg[k][l];
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cx_reg[0][l] <= {4'd0, root_reg[SQS][l], 8'd0};
                cy_reg[0][l] <= {{4{num_ci[15]}}, num_ci, 8'd0};
                cz_reg[0][l] <= '0;
            end
        end

        // vectoring CORDIC, one rotation a stage
        for (genvar c = 0; c < CS; c++)
        begin : g_cordic
            logic signed [XW-1:0] dx;
            logic signed [XW-1:0] dy;
            logic signed [ZW-1:0] at;

            assign dx = cy_reg[c][l] >>> c;
            assign dy = cx_reg[c][l] >>> c;
            assign at = $signed({2'b00, act_pkg::atan_val(c)});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!cy_reg[c][l][XW-1])
                    begin
                        cx_reg[c+1][l] <= cx_reg[c][l] + dx;
                        cy_reg[c+1][l] <= cy_reg[c][l] - dy;
                        cz_reg[c+1][l] <= cz_reg[c][l] + at;
                    end
                    else
                    begin
                        cx_reg[c+1][l] <= cx_reg[c][l] - dx;
                        cy_reg[c+1][l] <= cy_reg[c][l] + dy;
                        cz_reg[c+1][l] <= cz_reg[c][l] - at;
                    end
                end
            end
        end

        // 2^-16 degree to hundredths, round half up
        assign zp = $signed({{8{cz_reg[CS][l][ZW-1]}}, cz_reg[CS][l]}) * 33'sd100;
        assign hs = (zp + 33'sd32768) >>> 16;
        assign h  = hs[16:0];

        always_comb
        begin
            if (num_out == '0)
                ang_next = '0;
            else if (root_zero)
                ang_next = num_out[15] ? -15'sd9000 : 15'sd9000;
            else if (h > 17'sd9000)
                ang_next = 15'sd9000;
            else if (h < -17'sd9000)
                ang_next = -15'sd9000;
            else
                ang_next = h[14:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                ang_reg[l] <= ang_next;
        end
    end

    assign out_valid   = v_reg[P_OUT];
    assign calib_x     = axes_reg[P_OUT].x;
    assign calib_y     = axes_reg[P_OUT].y;
    assign calib_z     = axes_reg[P_OUT].z;
    assign pitch_angle = ang_reg[0];
    assign roll_angle  = ang_reg[1];

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int STEPS     = act_pkg::CORDIC_STEPS_DEF;
    localparam int LATENCY   = 21 + STEPS;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
        logic signed [14:0] pitch;
        logic signed [14:0] roll;
    } tilt_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] calib_x, calib_y, calib_z;
    logic signed [14:0] pitch_angle, roll_angle;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [act_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [act_pkg::OFF_W-1:0] cfg_data = '0;

    sample_t   pending_samples[$];
    tilt_res_t expected_tilt[$];
    longint    offset_model[3];
    longint    gain_model[3];
    int        mismatches = 0;
    int        samples_sent = 0;
    int        results_seen = 0;
    int        in_gap = 0;
    int        out_gap = 0;
    bit        quiet = 1'b0;

    accel_calibrated_tilt DUT (.*);

    always #4 clk = ~clk;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint calibrate_axis(longint raw, longint off, longint gain);
        longint q;
        q = floor_shift((raw * 256 - off) * gain + (64'sd1 <<< 21), 22);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q;
    endfunction

    function automatic longint root_floor(longint n);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > n) b = b >>> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint tilt_angle(longint num, longint a, longint b);
        longint r, cx, cy, acc, dx, dy, h;
        r = root_floor(a * a + b * b);
        if (num == 0) return 0;
        if (r == 0) return (num > 0) ? 9000 : -9000;
        cx = r * 256;
        cy = num * 256;
        acc = 0;
        for (int i = 0; i < STEPS && i < act_pkg::ATAN_ENTRIES; i++)
        begin
            dx = floor_shift(cy, i);
            dy = floor_shift(cx, i);
            if (cy >= 0)
            begin
                cx += dx; cy -= dy; acc += longint'(act_pkg::atan_val(i));
            end
            else
            begin
                cx -= dx; cy += dy; acc -= longint'(act_pkg::atan_val(i));
            end
        end
        h = floor_shift(acc * 100 + 32768, 16);
        if (h > 9000) h = 9000;
        if (h < -9000) h = -9000;
        return h;
    endfunction

    function automatic tilt_res_t predict_tilt(sample_t s);
        tilt_res_t t;
        longint c0, c1, c2;
        c0 = calibrate_axis(longint'(s.x), offset_model[0], gain_model[0]);
        c1 = calibrate_axis(longint'(s.y), offset_model[1], gain_model[1]);
        c2 = calibrate_axis(longint'(s.z), offset_model[2], gain_model[2]);
        t.cx = c0[15:0];
        t.cy = c1[15:0];
        t.cz = c2[15:0];
        t.pitch = 15'(tilt_angle(c1, c0, c2));
        t.roll  = 15'(tilt_angle(c0, c1, c2));
        return t;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!(in_valid && in_stall))
            begin
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 5) == 0)
                begin
                    in_gap <= $urandom_range(0, 2);
                    in_valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    sample_t s;
                    s = pending_samples.pop_front();
                    expected_tilt.push_back(predict_tilt(s));
                    accel_x <= s.x;
                    accel_y <= s.y;
                    accel_z <= s.z;
                    in_valid <= 1'b1;
                    samples_sent <= samples_sent + 1;
                end
                else
                    in_valid <= 1'b0;
            end
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_gap <= $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            tilt_res_t want;
            results_seen <= results_seen + 1;
            if (expected_tilt.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected item: %0d %0d %0d p=%0d r=%0d",
                             calib_x, calib_y, calib_z, pitch_angle, roll_angle);
            end
            else
            begin
                want = expected_tilt.pop_front();
                if (want.cx !== calib_x || want.cy !== calib_y ||
                    want.cz !== calib_z || want.pitch !== pitch_angle ||
                    want.roll !== roll_angle)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display({"mismatch: exp %0d %0d %0d p=%0d r=%0d",
                                  " got %0d %0d %0d p=%0d r=%0d"},
                                 want.cx, want.cy, want.cz, want.pitch, want.roll,
                                 calib_x, calib_y, calib_z, pitch_angle, roll_angle);
                end
            end
        end
    end

    task automatic write_reg(act_pkg::cfg_idx_t idx, logic [act_pkg::OFF_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx <= act_pkg::CFG_OFFSET_Z)
            offset_model[idx] = longint'(signed'(value));
        else
            gain_model[idx - act_pkg::CFG_GAIN_X] = longint'(value[act_pkg::GAIN_W-1:0]);
    endtask

    task automatic drain();
        wait (pending_samples.size() == 0 && !in_valid && expected_tilt.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic queue_random(int n, bit narrow);
        sample_t s;
        for (int i = 0; i < n; i++)
        begin
            if (narrow)
            begin
                s.x = 16'(int'($urandom_range(0, 4000)) - 2000);
                s.y = 16'(int'($urandom_range(0, 4000)) - 2000);
                s.z = 16'(int'($urandom_range(0, 4000)) - 2000);
            end
            else
            begin
                s.x = 16'($urandom);
                s.y = 16'($urandom);
                s.z = 16'($urandom);
                if ($urandom_range(0, 9) == 0) s.x = 0;
                if ($urandom_range(0, 9) == 0) s.y = 0;
                if ($urandom_range(0, 9) == 0) s.z = 0;
            end
            pending_samples.push_back(s);
        end
    endtask

    function automatic logic [act_pkg::OFF_W-1:0] offset_for_zero(logic signed [15:0] raw);
        return act_pkg::OFF_W'(longint'(raw) * 256);
    endfunction

    initial
    begin
        sample_t s;
        logic signed [15:0] ext[5];
        ext = '{16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1, 16'sd1};
        offset_model = '{longint'(signed'(act_pkg::OFF_X_RST)),
                         longint'(signed'(act_pkg::OFF_Y_RST)),
                         longint'(signed'(act_pkg::OFF_Z_RST))};
        gain_model = '{longint'(act_pkg::GAIN_X_RST), longint'(act_pkg::GAIN_Y_RST),
                       longint'(act_pkg::GAIN_Z_RST)};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: extremes of every axis
        for (int i = 0; i < 5; i++)
        begin
            s.x = ext[i]; s.y = ext[(i + 1) % 5]; s.z = ext[(i + 3) % 5];
            pending_samples.push_back(s);
        end
        queue_random(100, 1'b0);
        drain();

        // offsets equal to the raw sample: zero numerator and zero root cases
        write_reg(act_pkg::CFG_OFFSET_X, offset_for_zero(16'sd100));
        write_reg(act_pkg::CFG_OFFSET_Y, offset_for_zero(16'sd100));
        write_reg(act_pkg::CFG_OFFSET_Z, offset_for_zero(16'sd100));
        write_reg(act_pkg::CFG_GAIN_X, 24'd16384);
        write_reg(act_pkg::CFG_GAIN_Y, 24'd16384);
        write_reg(act_pkg::CFG_GAIN_Z, 24'd16384);
        s = '{16'sd100, 16'sd100, 16'sd100};  pending_samples.push_back(s);
        s = '{16'sd100, 16'sd300, 16'sd100};  pending_samples.push_back(s);
        s = '{16'sd100, -16'sd300, 16'sd100}; pending_samples.push_back(s);
        s = '{16'sd500, 16'sd100, 16'sd100};  pending_samples.push_back(s);
        s = '{-16'sd500, 16'sd100, 16'sd100}; pending_samples.push_back(s);
        s = '{16'sd101, 16'sd101, 16'sd100};  pending_samples.push_back(s);
        queue_random(150, 1'b1);
        drain();

        // extreme offsets and gains: saturation both ways
        write_reg(act_pkg::CFG_OFFSET_X, 24'h800000);
        write_reg(act_pkg::CFG_OFFSET_Y, 24'h7FFFFF);
        write_reg(act_pkg::CFG_OFFSET_Z, 24'h000000);
        write_reg(act_pkg::CFG_GAIN_X, 24'h00FFFF);
        write_reg(act_pkg::CFG_GAIN_Y, 24'h00FFFF);
        write_reg(act_pkg::CFG_GAIN_Z, 24'h000000);
        for (int i = 0; i < 5; i++)
        begin
            s.x = ext[i]; s.y = ext[(i + 2) % 5]; s.z = ext[(i + 4) % 5];
            pending_samples.push_back(s);
        end
        queue_random(250, 1'b0);
        drain();

        // random settings; data alternates between fully random bits and a narrow range
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(act_pkg::CFG_OFFSET_X, act_pkg::OFF_W'($urandom));
            write_reg(act_pkg::CFG_OFFSET_Y,
                      act_pkg::OFF_W'(int'($urandom_range(0, 8000)) - 4000));
            write_reg(act_pkg::CFG_OFFSET_Z, act_pkg::OFF_W'($urandom));
            write_reg(act_pkg::CFG_GAIN_X, act_pkg::OFF_W'($urandom_range(0, 65535)));
            write_reg(act_pkg::CFG_GAIN_Y, act_pkg::OFF_W'($urandom_range(12000, 20000)));
            write_reg(act_pkg::CFG_GAIN_Z, act_pkg::OFF_W'($urandom_range(0, 65535)));
            queue_random(150, ph[0]);
            drain();
        end

        // closing stretch without idling
        quiet = 1'b1;
        queue_random(200, 1'b1);
        drain();

        $display("Sent %0d samples over seven calibration settings, %0d results checked.",
                 samples_sent, results_seen);
        if (mismatches == 0)
            $display("PASS");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end
endmodule

FILE: accel_calibrated_tilt.f
+incdir+rtl/core
rtl/core/act_pkg.sv
rtl/core/act_front.sv
rtl/core/act_queue.sv
rtl/core/act_back.sv
rtl/core/accel_calibrated_tilt.sv
tb/testbench.sv
